/* hw/rtl/tlc_pkg.sv */
// Shared constants for the trajectory limit checker.
`default_nettype none

package tlc_pkg;

    localparam int TIME_W   = 24;
    localparam int VAL_W    = 16;
    localparam int BOUND_W  = 15;
    localparam int STATUS_W = 3;
    localparam int IDX_W    = 3;
    localparam int IN_DATA_W  = 72;
    localparam int OUT_DATA_W = 8;

    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 25;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic signed [TIME_W-1:0] TIME_LIMIT_MS = 24'sd8000;
    localparam logic signed [MUL_B_W-1:0] MS_PER_S = 25'sd1000;

    localparam logic [IDX_W-1:0] REG_SPEED_LOW       = 3'd0;
    localparam logic [IDX_W-1:0] REG_SPEED_HIGH      = 3'd1;
    localparam logic [IDX_W-1:0] REG_ACCEL_LOW       = 3'd2;
    localparam logic [IDX_W-1:0] REG_ACCEL_HIGH      = 3'd3;
    localparam logic [IDX_W-1:0] REG_CURVATURE_BOUND = 3'd4;
    localparam logic [IDX_W-1:0] REG_JERK_LOW        = 3'd5;
    localparam logic [IDX_W-1:0] REG_JERK_HIGH       = 3'd6;
    localparam logic [IDX_W-1:0] REG_LAT_ACCEL_BOUND = 3'd7;

    localparam logic signed [VAL_W-1:0] SPEED_LOW_RST  = -16'sd26;
    localparam logic signed [VAL_W-1:0] SPEED_HIGH_RST = 16'sd10240;
    localparam logic signed [VAL_W-1:0] ACCEL_LOW_RST  = -16'sd1152;
    localparam logic signed [VAL_W-1:0] ACCEL_HIGH_RST = 16'sd1024;
    localparam logic [BOUND_W-1:0]      CURV_BOUND_RST = 15'd811;
    localparam logic signed [VAL_W-1:0] JERK_LOW_RST   = -16'sd1024;
    localparam logic signed [VAL_W-1:0] JERK_HIGH_RST  = 16'sd512;
    localparam logic [BOUND_W-1:0]      LAT_BOUND_RST  = 15'd1024;

    localparam logic [1:0] FF_NONE  = 2'd0;
    localparam logic [1:0] FF_SPEED = 2'd1;
    localparam logic [1:0] FF_ACCEL = 2'd2;
    localparam logic [1:0] FF_CURV  = 2'd3;

    localparam logic [1:0] PF_NONE = 2'd0;
    localparam logic [1:0] PF_JERK = 2'd1;
    localparam logic [1:0] PF_LAT  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_VALID = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PAIR_BASE = 3'd3;

endpackage

`default_nettype wire

/* hw/rtl/tlc_mul.sv */
// Shared signed multiplier with a registered product.
`default_nettype none

module tlc_mul (
    input  wire logic                                 i_clk,
    input  wire logic signed [tlc_pkg::MUL_A_W-1:0]   i_a,
    input  wire logic signed [tlc_pkg::MUL_B_W-1:0]   i_b,
    output logic signed [tlc_pkg::MUL_P_W-1:0]        o_prod
);

    logic signed [tlc_pkg::MUL_P_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

/* hw/rtl/trajectory_limit_checker_core.sv */
// Top level of the trajectory limit checker.
//
// Points arrive one per input transfer; tlast marks the final point of a trajectory, and
// only that point produces an output transfer carrying the status code (0 valid, 1 speed,
// 2 accel, 3 curvature, 4 jerk, 5 lateral accel). Speed, acceleration and curvature
// bounds are compared in the cycle a point is accepted. The jerk and lateral-acceleration
// checks on a pair of points run on one registered multiplier under a small sequencer:
// with no pair check a point goes to the final step, else the sequencer forms the
// acceleration difference, the low and high jerk products and the jerk check and, if that
// passes, the v*v and v*v*kappa products and the lateral check. A last point also waits
// in the final step while the previous status transfer is held at the output; the input
// is not ready while a point is in work. Configuration writes are accepted at any time
// outside reset but must only be made while no trajectory is in progress.
`default_nettype none

module trajectory_limit_checker_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // tdata: point_time[23:0], speed[39:24], accel[55:40], curvature[71:56]
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    input  wire logic [tlc_pkg::IN_DATA_W-1:0]       i_s_tdata,
    input  wire logic                                i_s_tlast,
    // tdata: status[2:0], zeros above
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    output logic [tlc_pkg::OUT_DATA_W-1:0]           o_m_tdata,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [tlc_pkg::IDX_W-1:0]           i_cfg_index,
    input  wire logic [tlc_pkg::VAL_W-1:0]           i_cfg_data
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DA   = 4'd1;
    localparam logic [3:0] S_JL   = 4'd2;
    localparam logic [3:0] S_JH   = 4'd3;
    localparam logic [3:0] S_JCHK = 4'd4;
    localparam logic [3:0] S_VV   = 4'd5;
    localparam logic [3:0] S_LAT  = 4'd6;
    localparam logic [3:0] S_LCHK = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    // Configuration registers.
    logic signed [tlc_pkg::VAL_W-1:0] r_speed_low, r_speed_high, r_accel_low, r_accel_high;
    logic signed [tlc_pkg::VAL_W-1:0] r_jerk_low, r_jerk_high;
    logic [tlc_pkg::BOUND_W-1:0]      r_curv_bound, r_lat_bound;

    // Trajectory state.
    logic [3:0] r_state, n_state;
    logic signed [tlc_pkg::TIME_W-1:0] r_prev_time, n_prev_time;
    logic signed [tlc_pkg::VAL_W-1:0]  r_prev_accel, n_prev_accel;
    logic r_have_prev, n_have_prev;
    logic r_past_limit, n_past_limit;
    logic r_pair_stop, n_pair_stop;
    logic [1:0] r_first_fault, n_first_fault;
    logic [1:0] r_pair_fault, n_pair_fault;
    logic r_out_valid, n_out_valid;
    logic [tlc_pkg::STATUS_W-1:0] r_status, n_status;

    // Per-point working registers.
    logic signed [tlc_pkg::MUL_B_W-1:0] r_dt;
    logic signed [tlc_pkg::VAL_W:0]     r_dd;
    logic signed [tlc_pkg::VAL_W-1:0]   r_v, r_k;
    logic r_last;
    logic r_pair_go;
    logic signed [27:0] r_da;
    logic signed [40:0] r_jl;

    logic s_accept;
    logic signed [tlc_pkg::TIME_W-1:0] s_t;
    logic signed [tlc_pkg::VAL_W-1:0]  s_v, s_a, s_k;
    logic s_beyond;
    logic signed [tlc_pkg::VAL_W:0] s_curv_hi, s_curv_lo, s_k_ext;
    logic signed [tlc_pkg::MUL_A_W-1:0] s_op_a;
    logic signed [tlc_pkg::MUL_B_W-1:0] s_op_b;
    logic signed [tlc_pkg::MUL_P_W-1:0] s_prod;
    logic signed [40:0] s_da_ext, s_jh;
    logic s_jerk_fault;
    logic signed [46:0] s_lat, s_lim;
    logic s_lat_fault;
    logic s_out_free;

    assign o_s_tready  = i_rst_n && (r_state == S_IDLE);
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = i_rst_n;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {{(tlc_pkg::OUT_DATA_W - tlc_pkg::STATUS_W){1'b0}}, r_status};

    assign s_t = i_s_tdata[23:0];
    assign s_v = i_s_tdata[39:24];
    assign s_a = i_s_tdata[55:40];
    assign s_k = i_s_tdata[71:56];
    assign s_beyond = (s_t > tlc_pkg::TIME_LIMIT_MS);

    assign s_k_ext   = {s_k[tlc_pkg::VAL_W-1], s_k};
    assign s_curv_hi = {2'b00, r_curv_bound};
    assign s_curv_lo = -s_curv_hi;

    tlc_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (s_op_a),
        .i_b    (s_op_b),
        .o_prod (s_prod)
    );

    always_comb begin
        s_op_a = '0;
        s_op_b = '0;
        case (r_state)
            S_DA: begin
                s_op_a = {{16{r_dd[16]}}, r_dd};
                s_op_b = tlc_pkg::MS_PER_S;
            end
            S_JL: begin
                s_op_a = {{17{r_jerk_low[15]}}, r_jerk_low};
                s_op_b = r_dt;
            end
            S_JH: begin
                s_op_a = {{17{r_jerk_high[15]}}, r_jerk_high};
                s_op_b = r_dt;
            end
            S_VV: begin
                s_op_a = {{17{r_v[15]}}, r_v};
                s_op_b = {{9{r_v[15]}}, r_v};
            end
            S_LAT: begin
                s_op_a = s_prod[tlc_pkg::MUL_A_W-1:0];
                s_op_b = {{9{r_k[15]}}, r_k};
            end
            default: begin
                s_op_a = '0;
                s_op_b = '0;
            end
        endcase
    end

    assign s_da_ext = {{13{r_da[27]}}, r_da};
    assign s_jh     = s_prod[40:0];
    assign s_jerk_fault = (r_dt <= 0) || (s_da_ext < r_jl) || (s_da_ext > s_jh);

    assign s_lat = s_prod[46:0];
    assign s_lim = {12'd0, r_lat_bound, 20'd0};
    assign s_lat_fault = (s_lat > s_lim) || (s_lat < -s_lim);

    assign s_out_free = !r_out_valid || i_m_tready;

    always_comb begin
        n_state       = r_state;
        n_prev_time   = r_prev_time;
        n_prev_accel  = r_prev_accel;
        n_have_prev   = r_have_prev;
        n_past_limit  = r_past_limit;
        n_pair_stop   = r_pair_stop;
        n_first_fault = r_first_fault;
        n_pair_fault  = r_pair_fault;
        n_out_valid   = r_out_valid && !i_m_tready;
        n_status      = r_status;

        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    if (!r_past_limit) begin
                        if (s_beyond) begin
                            n_past_limit = 1'b1;
                        end else if (r_first_fault == tlc_pkg::FF_NONE) begin
                            if (s_v < r_speed_low || s_v > r_speed_high) begin
                                n_first_fault = tlc_pkg::FF_SPEED;
                            end else if (s_a < r_accel_low || s_a > r_accel_high) begin
                                n_first_fault = tlc_pkg::FF_ACCEL;
                            end else if (s_k_ext < s_curv_lo || s_k_ext > s_curv_hi) begin
                                n_first_fault = tlc_pkg::FF_CURV;
                            end
                        end
                    end
                    if (r_have_prev && !r_pair_stop && s_beyond) begin
                        n_pair_stop = 1'b1;
                    end
                    n_prev_time  = s_t;
                    n_prev_accel = s_a;
                    n_have_prev  = 1'b1;
                    if (r_have_prev && !r_pair_stop && !s_beyond &&
                        r_pair_fault == tlc_pkg::PF_NONE) begin
                        n_state = S_DA;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_DA:   n_state = S_JL;
            S_JL:   n_state = S_JH;
            S_JH:   n_state = S_JCHK;
            S_JCHK: begin
                if (s_jerk_fault) begin
                    n_pair_fault = tlc_pkg::PF_JERK;
                    n_state = S_FIN;
                end else begin
                    n_state = S_VV;
                end
            end
            S_VV:   n_state = S_LAT;
            S_LAT:  n_state = S_LCHK;
            S_LCHK: begin
                if (s_lat_fault) begin
                    n_pair_fault = tlc_pkg::PF_LAT;
                end
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if (s_out_free) begin
                    n_out_valid = 1'b1;
                    if (r_first_fault != tlc_pkg::FF_NONE) begin
                        n_status = {1'b0, r_first_fault};
                    end else if (r_pair_fault != tlc_pkg::PF_NONE) begin
                        n_status = tlc_pkg::ST_PAIR_BASE + {1'b0, r_pair_fault};
                    end else begin
                        n_status = tlc_pkg::ST_VALID;
                    end
                    n_prev_time   = '0;
                    n_prev_accel  = '0;
                    n_have_prev   = 1'b0;
                    n_past_limit  = 1'b0;
                    n_pair_stop   = 1'b0;
                    n_first_fault = tlc_pkg::FF_NONE;
                    n_pair_fault  = tlc_pkg::PF_NONE;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_prev_time   <= '0;
            r_prev_accel  <= '0;
            r_have_prev   <= 1'b0;
            r_past_limit  <= 1'b0;
            r_pair_stop   <= 1'b0;
            r_first_fault <= tlc_pkg::FF_NONE;
            r_pair_fault  <= tlc_pkg::PF_NONE;
            r_out_valid   <= 1'b0;
            r_status      <= tlc_pkg::ST_VALID;
        end else begin
            r_state       <= n_state;
            r_prev_time   <= n_prev_time;
            r_prev_accel  <= n_prev_accel;
            r_have_prev   <= n_have_prev;
            r_past_limit  <= n_past_limit;
            r_pair_stop   <= n_pair_stop;
            r_first_fault <= n_first_fault;
            r_pair_fault  <= n_pair_fault;
            r_out_valid   <= n_out_valid;
            r_status      <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_low  <= tlc_pkg::SPEED_LOW_RST;
            r_speed_high <= tlc_pkg::SPEED_HIGH_RST;
            r_accel_low  <= tlc_pkg::ACCEL_LOW_RST;
            r_accel_high <= tlc_pkg::ACCEL_HIGH_RST;
            r_curv_bound <= tlc_pkg::CURV_BOUND_RST;
            r_jerk_low   <= tlc_pkg::JERK_LOW_RST;
            r_jerk_high  <= tlc_pkg::JERK_HIGH_RST;
            r_lat_bound  <= tlc_pkg::LAT_BOUND_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                tlc_pkg::REG_SPEED_LOW:       r_speed_low  <= i_cfg_data;
                tlc_pkg::REG_SPEED_HIGH:      r_speed_high <= i_cfg_data;
                tlc_pkg::REG_ACCEL_LOW:       r_accel_low  <= i_cfg_data;
                tlc_pkg::REG_ACCEL_HIGH:      r_accel_high <= i_cfg_data;
                tlc_pkg::REG_CURVATURE_BOUND: r_curv_bound <= i_cfg_data[14:0];
                tlc_pkg::REG_JERK_LOW:        r_jerk_low   <= i_cfg_data;
                tlc_pkg::REG_JERK_HIGH:       r_jerk_high  <= i_cfg_data;
                tlc_pkg::REG_LAT_ACCEL_BOUND: r_lat_bound  <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_dt <= {s_t[23], s_t} - {r_prev_time[23], r_prev_time};
            r_dd <= {s_a[15], s_a} - {r_prev_accel[15], r_prev_accel};
            r_v    <= s_v;
            r_k    <= s_k;
            r_last <= i_s_tlast;
            r_pair_go <= r_have_prev && !r_pair_stop && !s_beyond;
        end
        if (r_state == S_JL) begin
            r_da <= s_prod[27:0];
        end
        if (r_state == S_JH && r_pair_go) begin
            r_jl <= s_prod[40:0];
        end
    end

endmodule

`default_nettype wire
